FILE: hdl/thds_pkg.sv
// ----------------------------------------------------------------------------
// Triangle hit and depth select package
// Shared types, constants and saturation helpers for the hit test block.
// ----------------------------------------------------------------------------
package thds_pkg;

  localparam int unsigned THDS_MAX_TRIS   = 256;
  localparam int unsigned THDS_QDEPTH     = 8;
  localparam int unsigned THDS_QPTR_W     = $clog2(THDS_QDEPTH);
  localparam int unsigned THDS_QLVL_W     = $clog2(THDS_QDEPTH + 1);
  localparam int unsigned THDS_BARY_W     = 17;
  localparam logic signed [63:0] THDS_ONE = 64'sd65536;
  localparam logic signed [31:0] THDS_DEPTH_INIT = 32'sh7FFF_FFFF;

  // One classified triangle word passed from the front to the back.
  typedef struct packed {
    logic                     covers;
    logic                     last;
    logic signed [31:0]       depth;
    logic [THDS_BARY_W-1:0]   u;
    logic [THDS_BARY_W-1:0]   v;
    logic [THDS_BARY_W-1:0]   w;
  } thds_entry_t;

  function automatic logic signed [31:0] thds_sat33(input logic signed [32:0] x);
    logic signed [31:0] r;
    if (x[32] != x[31]) begin
      r = x[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] thds_sat64(input logic signed [63:0] x);
    logic signed [31:0] r;
    if (!x[63] && (|x[62:31])) begin
      r = 32'sh7FFF_FFFF;
    end else if (x[63] && !(&x[62:31])) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

FILE: hdl/thds_front.sv
// ----------------------------------------------------------------------------
// Triangle hit front end
// Accepts triangle words, computes the barycentric weights in a four-stage
// pipeline and classifies coverage before pushing into the queue.
// ----------------------------------------------------------------------------
module thds_front
  import thds_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [31:0]     pixel_x_i,
  input  logic signed [31:0]     pixel_y_i,
  input  logic signed [31:0]     vertex_x_i,
  input  logic signed [31:0]     vertex_y_i,
  input  logic signed [31:0]     edge_a_x_i,
  input  logic signed [31:0]     edge_a_y_i,
  input  logic signed [31:0]     edge_b_x_i,
  input  logic signed [31:0]     edge_b_y_i,
  input  logic signed [31:0]     inv_denom_i,
  input  logic signed [31:0]     tri_depth_i,
  input  logic                   last_tri_i,
  input  logic [THDS_QLVL_W-1:0] q_level_i,
  output logic                   push_o,
  output thds_entry_t            push_entry_o
);

  logic accept;
  logic [THDS_QLVL_W:0] occupancy;

  // Stage valids.
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q;

  // Stage 1: differences.
  logic signed [31:0] dx_q, dy_q, ax_q, ay_q, bx_q, by_q, inv1_q, dep1_q;
  logic               last1_q;
  // Stage 2: cross products.
  logic signed [63:0] m_dxby_q, m_bxdy_q, m_axdy_q, m_dxay_q;
  logic signed [31:0] inv2_q, dep2_q;
  logic               last2_q;
  // Stage 3: saturated cross terms.
  logic signed [63:0] t_v, t_w;
  logic signed [31:0] cv_q, cw_q, inv3_q, dep3_q;
  logic               last3_q;
  // Stage 4: scaled weights.
  logic signed [63:0] pv_q, pw_q;
  logic signed [31:0] dep4_q;
  logic               last4_q;

  logic signed [63:0] v_s, w_s, u_s;

  assign occupancy = {1'b0, q_level_i}
                   + (THDS_QLVL_W + 1)'(s1_vld_q) + (THDS_QLVL_W + 1)'(s2_vld_q)
                   + (THDS_QLVL_W + 1)'(s3_vld_q) + (THDS_QLVL_W + 1)'(s4_vld_q);
  assign in_stall_o = occupancy >= (THDS_QLVL_W + 1)'(THDS_QDEPTH);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= accept;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
    end
  end

  assign t_v = (m_dxby_q >>> 16) - (m_bxdy_q >>> 16);
  assign t_w = (m_axdy_q >>> 16) - (m_dxay_q >>> 16);

  always_ff @(posedge clk_i) begin
    dx_q     <= thds_sat33({pixel_x_i[31], pixel_x_i} - {vertex_x_i[31], vertex_x_i});
    dy_q     <= thds_sat33({pixel_y_i[31], pixel_y_i} - {vertex_y_i[31], vertex_y_i});
    ax_q     <= edge_a_x_i;
    ay_q     <= edge_a_y_i;
    bx_q     <= edge_b_x_i;
    by_q     <= edge_b_y_i;
    inv1_q   <= inv_denom_i;
    dep1_q   <= tri_depth_i;
    last1_q  <= last_tri_i;

    m_dxby_q <= dx_q * by_q;
    m_bxdy_q <= bx_q * dy_q;
    m_axdy_q <= ax_q * dy_q;
    m_dxay_q <= dx_q * ay_q;
    inv2_q   <= inv1_q;
    dep2_q   <= dep1_q;
    last2_q  <= last1_q;

    cv_q     <= thds_sat64(t_v);
    cw_q     <= thds_sat64(t_w);
    inv3_q   <= inv2_q;
    dep3_q   <= dep2_q;
    last3_q  <= last2_q;

    pv_q     <= cv_q * inv3_q;
    pw_q     <= cw_q * inv3_q;
    dep4_q   <= dep3_q;
    last4_q  <= last3_q;
  end

  assign v_s = pv_q >>> 16;
  assign w_s = pw_q >>> 16;
  assign u_s = THDS_ONE - v_s - w_s;

  always_comb begin
    push_o              = s4_vld_q;
    push_entry_o.covers = !v_s[63] && !w_s[63] && (v_s <= THDS_ONE) && (w_s <= THDS_ONE)
                          && (u_s > 64'sd0);
    push_entry_o.last   = last4_q;
    push_entry_o.depth  = dep4_q;
    push_entry_o.u      = u_s[THDS_BARY_W-1:0];
    push_entry_o.v      = v_s[THDS_BARY_W-1:0];
    push_entry_o.w      = w_s[THDS_BARY_W-1:0];
  end

endmodule

FILE: hdl/thds_queue.sv
// ----------------------------------------------------------------------------
// Triangle hit queue
// Short first-in first-out buffer of classified words between front and back.
// ----------------------------------------------------------------------------
module thds_queue
  import thds_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  thds_entry_t            entry_i,
  input  logic                   pop_i,
  output logic                   valid_o,
  output thds_entry_t            entry_o,
  output logic [THDS_QLVL_W-1:0] level_o
);

  thds_entry_t            mem_q [THDS_QDEPTH];
  logic [THDS_QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [THDS_QLVL_W-1:0] level_q;
  logic                   do_pop;

  assign do_pop  = pop_i && (level_q != '0);
  assign valid_o = level_q != '0;
  assign entry_o = mem_q[rd_ptr_q];
  assign level_o = level_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + THDS_QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + THDS_QPTR_W'(1);
      end
      if (push_i && !do_pop) begin
        level_q <= level_q + THDS_QLVL_W'(1);
      end else if (!push_i && do_pop) begin
        level_q <= level_q - THDS_QLVL_W'(1);
      end
    end
  end

endmodule

FILE: hdl/thds_back.sv
// ----------------------------------------------------------------------------
// Triangle hit back end
// Keeps the nearest covering triangle of the current pixel and presents the
// result word in an output register when the last triangle arrives.
// ----------------------------------------------------------------------------
module thds_back
  import thds_pkg::*;
#(
  parameter int unsigned MAX_TRIS = THDS_MAX_TRIS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  thds_entry_t            q_entry_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   hit_o,
  output logic [7:0]             tri_index_o,
  output logic [THDS_BARY_W-1:0] bary_u_o,
  output logic [THDS_BARY_W-1:0] bary_v_o,
  output logic [THDS_BARY_W-1:0] bary_w_o
);

  localparam int unsigned CntW = $clog2(MAX_TRIS);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_TRIS - 1);

  logic signed [31:0]     best_depth_q, best_depth_d;
  logic                   found_q, found_d;
  logic [CntW-1:0]        slot_q, slot_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [THDS_BARY_W-1:0] u_q, u_d, v_q, v_d, w_q, w_d;
  logic                   out_vld_q, out_vld_d;

  logic                   pop, win, emit;
  logic                   sel_found;
  logic [CntW-1:0]        sel_slot;
  logic [THDS_BARY_W-1:0] sel_u, sel_v, sel_w;
  logic [CntW+7:0]        slot_ext;

  assign pop     = q_valid_i && (!out_vld_q || !out_stall_i);
  assign q_pop_o = pop;
  assign win     = pop && q_entry_i.covers && (q_entry_i.depth < best_depth_q);
  assign emit    = pop && q_entry_i.last;

  assign sel_found = found_q || win;
  assign sel_slot  = win ? count_q : slot_q;
  assign sel_u     = win ? q_entry_i.u : u_q;
  assign sel_v     = win ? q_entry_i.v : v_q;
  assign sel_w     = win ? q_entry_i.w : w_q;
  assign slot_ext  = {8'b0, sel_slot};

  always_comb begin
    best_depth_d = win ? q_entry_i.depth : best_depth_q;
    found_d      = sel_found;
    slot_d       = sel_slot;
    u_d          = sel_u;
    v_d          = sel_v;
    w_d          = sel_w;
    count_d      = count_q;
    if (pop && (count_q < CntMax)) begin
      count_d = count_q + CntW'(1);
    end
    if (emit) begin
      best_depth_d = THDS_DEPTH_INIT;
      found_d      = 1'b0;
      slot_d       = '0;
      u_d          = '0;
      v_d          = '0;
      w_d          = '0;
      count_d      = '0;
    end
    out_vld_d = out_vld_q;
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_depth_q <= THDS_DEPTH_INIT;
      found_q      <= 1'b0;
      slot_q       <= '0;
      count_q      <= '0;
      u_q          <= '0;
      v_q          <= '0;
      w_q          <= '0;
      out_vld_q    <= 1'b0;
    end else begin
      best_depth_q <= best_depth_d;
      found_q      <= found_d;
      slot_q       <= slot_d;
      count_q      <= count_d;
      u_q          <= u_d;
      v_q          <= v_d;
      w_q          <= w_d;
      out_vld_q    <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      hit_o       <= sel_found;
      tri_index_o <= slot_ext[7:0];
      bary_u_o    <= sel_u;
      bary_v_o    <= sel_v;
      bary_w_o    <= sel_w;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

FILE: hdl/triangle_hit_depth_select_unit.sv
// Throughput: one triangle word per cycle while the eight-entry queue and the
// four-stage multiply pipeline ahead of it have room; the queue credit sets it.
// Reset: asynchronous and active low; it empties the pipeline and queue and
// returns the nearest-hit state to no hit, position zero and maximum depth.
// ----------------------------------------------------------------------------
// Triangle hit and depth select unit
// Tests candidate triangles against a pixel and returns the nearest hit.
// ----------------------------------------------------------------------------
module triangle_hit_depth_select_unit
  import thds_pkg::*;
#(
  parameter int unsigned MAX_TRIS = THDS_MAX_TRIS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [31:0]     pixel_x_i,
  input  logic signed [31:0]     pixel_y_i,
  input  logic signed [31:0]     vertex_x_i,
  input  logic signed [31:0]     vertex_y_i,
  input  logic signed [31:0]     edge_a_x_i,
  input  logic signed [31:0]     edge_a_y_i,
  input  logic signed [31:0]     edge_b_x_i,
  input  logic signed [31:0]     edge_b_y_i,
  input  logic signed [31:0]     inv_denom_i,
  input  logic signed [31:0]     tri_depth_i,
  input  logic                   last_tri_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic                   hit_o,
  output logic [7:0]             tri_index_o,
  output logic [THDS_BARY_W-1:0] bary_u_o,
  output logic [THDS_BARY_W-1:0] bary_v_o,
  output logic [THDS_BARY_W-1:0] bary_w_o
);

  logic                   q_push, q_pop, q_valid;
  thds_entry_t            q_wr_entry, q_rd_entry;
  logic [THDS_QLVL_W-1:0] q_level;

  thds_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_x_i    (pixel_x_i),
    .pixel_y_i    (pixel_y_i),
    .vertex_x_i   (vertex_x_i),
    .vertex_y_i   (vertex_y_i),
    .edge_a_x_i   (edge_a_x_i),
    .edge_a_y_i   (edge_a_y_i),
    .edge_b_x_i   (edge_b_x_i),
    .edge_b_y_i   (edge_b_y_i),
    .inv_denom_i  (inv_denom_i),
    .tri_depth_i  (tri_depth_i),
    .last_tri_i   (last_tri_i),
    .q_level_i    (q_level),
    .push_o       (q_push),
    .push_entry_o (q_wr_entry)
  );

  thds_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_wr_entry),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .entry_o (q_rd_entry),
    .level_o (q_level)
  );

  thds_back #(
    .MAX_TRIS (MAX_TRIS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (q_rd_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .hit_o       (hit_o),
    .tri_index_o (tri_index_o),
    .bary_u_o    (bary_u_o),
    .bary_v_o    (bary_v_o),
    .bary_w_o    (bary_w_o)
  );

`ifndef SYNTHESIS
  // The queue credit must never let a word arrive at a full queue.
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> (q_level < THDS_QLVL_W'(THDS_QDEPTH)))
    else $error("queue written while full");

  // A word with no hit carries zero index and weights.
  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (tri_index_o == 8'd0 && bary_u_o == '0 &&
                                 bary_v_o == '0 && bary_w_o == '0))
    else $error("miss word carries non-zero fields");

  // The weights of a hit sum to one and u is strictly positive.
  a_hit_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_o) |-> (bary_u_o != '0 &&
      ({1'b0, bary_u_o} + {1'b0, bary_v_o} + {1'b0, bary_w_o}) == 18'd65536))
    else $error("hit weights do not sum to one");
`endif

endmodule
